FILE: src/rv32i_subset_execute_macros.svh
// Assertion macros for the execute block.
`ifndef RV32I_SUBSET_EXECUTE_MACROS_SVH
`define RV32I_SUBSET_EXECUTE_MACROS_SVH
`ifndef SYNTH
`define RVX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RVX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RVX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RVX_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/rvx_pkg.sv
// ---------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32I subset execute block.
// ---------------------------------------------------------------------------
package rvx_pkg;
	localparam int MemWords = 1024;
	localparam int MemAw = $clog2(MemWords);
	localparam int QDepth = 2;
	localparam int QAw = 1;

	typedef enum logic [3:0] {
		OP_ADDI = 4'd0, OP_SLTI = 4'd1, OP_SLTIU = 4'd2, OP_XORI = 4'd3,
		OP_ORI = 4'd4, OP_ANDI = 4'd5, OP_JALR = 4'd6, OP_LW = 4'd7,
		OP_SLLI = 4'd8, OP_SRLI = 4'd9, OP_SRAI = 4'd10, OP_AUIPC = 4'd11,
		OP_SW = 4'd12, OP_BAD13 = 4'd13, OP_BAD14 = 4'd14, OP_BAD15 = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [4:0]  dest_index;
		logic [4:0]  src_one_index;
		logic [4:0]  src_two_index;
		logic [19:0] imm_bits;
	} req_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        mem_write;
		logic        illegal;
	} rsp_t;

	// Decoded item handed from the front to the back.
	typedef struct packed {
		op_t         op;
		logic        legal;
		logic        wr_reg;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		logic [19:0] uimm;
	} dec_t;
endpackage

FILE: src/rvx_front.sv
// ---------------------------------------------------------------------------
// rvx_front
// Decodes requests and buffers them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`include "rv32i_subset_execute_macros.svh"
module rvx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  rvx_pkg::req_t    req,
	output logic             dec_valid,
	input  logic             dec_ready,
	output rvx_pkg::dec_t    dec
);
	rvx_pkg::dec_t           slot_q [rvx_pkg::QDepth];
	logic [rvx_pkg::QAw-1:0] wr_ptr_q, rd_ptr_q;
	logic [rvx_pkg::QAw:0]   count_q;
	rvx_pkg::dec_t           d;
	logic                    push, pop;

	always_comb begin
		d.op     = rvx_pkg::op_t'(req.req_type);
		d.legal  = req.req_type <= 4'(rvx_pkg::OP_SW);
		d.wr_reg = d.legal && d.op != rvx_pkg::OP_SW && req.dest_index != 5'd0;
		d.rd     = req.dest_index;
		d.rs1    = req.src_one_index;
		d.rs2    = req.src_two_index;
		d.imm    = {{20{req.imm_bits[11]}}, req.imm_bits[11:0]};
		d.uimm   = req.imm_bits;
	end

	assign req_ready = count_q != (rvx_pkg::QAw+1)'(rvx_pkg::QDepth);
	assign dec_valid = count_q != '0;
	assign dec       = slot_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = dec_valid && dec_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (rvx_pkg::QAw+1)'(push) - (rvx_pkg::QAw+1)'(pop);
		end
	end

	`RVX_ASSERT_IMP(a_no_overfill, clk, arst_n, 1'b1, count_q <= (rvx_pkg::QAw+1)'(rvx_pkg::QDepth))
	`RVX_ASSERT_NXT(a_push_only, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`RVX_ASSERT_NXT(a_pop_only, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1)
endmodule

FILE: src/rvx_back.sv
// ---------------------------------------------------------------------------
// rvx_back
// Executes decoded items against the pc, register file and data memory.
// Load data comes from the registered memory read, taken together with the
// rest of the result, so loads leave at the same rate as other items.
// ---------------------------------------------------------------------------
`include "rv32i_subset_execute_macros.svh"
module rvx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          dec_valid,
	output logic          dec_ready,
	input  rvx_pkg::dec_t dec,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rvx_pkg::rsp_t rsp
);
	localparam int Aw = rvx_pkg::MemAw;
	localparam int CntW = Aw + 1;

	logic [31:0]   pc_q;
	logic [31:0]   rf_q [32];
	logic [31:0]   mem_q [rvx_pkg::MemWords];
	logic [CntW-1:0] clr_q;
	logic          clearing;
	// Result stage: held response plus load pending flag.
	logic          valid_s1, load_s1;
	rvx_pkg::rsp_t rsp_s1;
	logic [31:0]   rdata_s1;
	logic [31:0]   a, b, sum, val, nxt;
	logic [4:0]    sh;
	logic [Aw-1:0] widx;
	logic          fire, fwd_a, fwd_b;
	rvx_pkg::rsp_t r;

	assign clearing = !clr_q[Aw];
	assign dec_ready = !clearing && (!valid_s1 || rsp_ready);
	assign fire = dec_valid && dec_ready;

	// Bypass a load still in the result stage, whose value is not yet in the file.
	assign fwd_a = valid_s1 && load_s1 && rsp_s1.written_index == dec.rs1;
	assign fwd_b = valid_s1 && load_s1 && rsp_s1.written_index == dec.rs2;

	always_comb begin
		a = dec.rs1 == 5'd0 ? 32'd0 : (fwd_a ? rdata_s1 : rf_q[dec.rs1]);
		b = dec.rs2 == 5'd0 ? 32'd0 : (fwd_b ? rdata_s1 : rf_q[dec.rs2]);
		sum = a + dec.imm;
		sh  = dec.uimm[4:0];
		widx = sum[Aw+1:2];
		nxt = pc_q + 32'd4;
		val = 32'd0;
		case (dec.op)
			rvx_pkg::OP_ADDI:  val = sum;
			rvx_pkg::OP_SLTI:  val = {31'd0, $signed(a) < $signed(dec.imm)};
			rvx_pkg::OP_SLTIU: val = {31'd0, a < dec.imm};
			rvx_pkg::OP_XORI:  val = a ^ dec.imm;
			rvx_pkg::OP_ORI:   val = a | dec.imm;
			rvx_pkg::OP_ANDI:  val = a & dec.imm;
			rvx_pkg::OP_JALR: begin
				val = pc_q + 32'd4;
				nxt = {sum[31:1], 1'b0};
			end
			// The loaded word is put in place in the result stage.
			rvx_pkg::OP_LW:    val = 32'd0;
			rvx_pkg::OP_SLLI:  val = a << sh;
			rvx_pkg::OP_SRLI:  val = a >> sh;
			rvx_pkg::OP_SRAI:  val = $unsigned($signed(a) >>> sh);
			rvx_pkg::OP_AUIPC: val = pc_q + {dec.uimm, 12'd0};
			rvx_pkg::OP_SW:    val = b;
			default: begin
				nxt = pc_q;
				val = 32'd0;
			end
		endcase
		r.next_pc       = nxt;
		r.reg_write     = dec.wr_reg;
		r.written_index = dec.wr_reg ? dec.rd : 5'd0;
		r.written_value = (dec.wr_reg || dec.op == rvx_pkg::OP_SW) ? val : 32'd0;
		r.mem_write     = dec.op == rvx_pkg::OP_SW;
		r.illegal       = !dec.legal;
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem_q[clr_q[Aw-1:0]] <= 32'd0;
		end else if (fire && dec.op == rvx_pkg::OP_SW) begin
			mem_q[widx] <= b;
		end
		if (fire) begin
			rdata_s1 <= mem_q[widx];
			rsp_s1   <= r;
		end
	end

	// Register file: ALU results at issue, load data when the result leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
		end else begin
			if (valid_s1 && load_s1 && (rsp_ready || fire))
				rf_q[rsp_s1.written_index] <= rdata_s1;
			if (fire && dec.wr_reg && dec.op != rvx_pkg::OP_LW)
				rf_q[dec.rd] <= val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 32'd0;
			clr_q    <= '0;
			valid_s1 <= 1'b0;
			load_s1  <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (fire) begin
				pc_q     <= nxt;
				valid_s1 <= 1'b1;
				load_s1  <= dec.wr_reg && dec.op == rvx_pkg::OP_LW;
			end else if (rsp_ready) begin
				valid_s1 <= 1'b0;
				load_s1  <= 1'b0;
			end
		end
	end

	always_comb begin
		rsp = rsp_s1;
		if (load_s1) rsp.written_value = rdata_s1;
	end
	assign rsp_valid = valid_s1;

	`RVX_ASSERT_IMP(a_no_issue_clear, clk, arst_n, clearing, !dec_ready)
	`RVX_ASSERT_NXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`RVX_ASSERT_IMP(a_load_writes, clk, arst_n, load_s1, valid_s1 && rsp_s1.reg_write)
endmodule

FILE: src/rv32i_subset_execute.sv
// ---------------------------------------------------------------------------
// rv32i_subset_execute
// Executes an RV32I subset instruction per transfer.
// ---------------------------------------------------------------------------
// Channel | Signals                    | Direction
// req     | req_valid, req_ready, req  | in
// rsp     | rsp_valid, rsp_ready, rsp  | out
//
// One instruction per cycle sustained while the output does not stall; items pass
// through the queue, then the result register, which holds the lw memory read.
// After reset the data memory is cleared one word a cycle; no transfer is taken
// from the queue until every word is cleared.
// A stalled output stops the back end; the two-entry queue accepts until full.
// ---------------------------------------------------------------------------
module rv32i_subset_execute (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rvx_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rvx_pkg::rsp_t rsp
);
	logic          dec_valid, dec_ready;
	rvx_pkg::dec_t dec;

	rvx_front u_front (
		.clk, .arst_n, .req_valid, .req_ready, .req,
		.dec_valid, .dec_ready, .dec
	);

	rvx_back u_back (
		.clk, .arst_n, .dec_valid, .dec_ready, .dec,
		.rsp_valid, .rsp_ready, .rsp
	);
endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives decoded RV32I subset instructions into the execute block and checks
// every response against a cycle-free model of the pc, registers and memory.
// ---------------------------------------------------------------------------
module tb_top;
	localparam int MaxCycles = 400000;
	localparam int NumRandom = 1250;
	localparam int NumDirected = 22;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	rvx_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	rvx_pkg::rsp_t rsp;

	rv32i_subset_execute uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Model state.
	logic [31:0] model_pc;
	logic [31:0] model_regs [32];
	logic [31:0] model_mem [rvx_pkg::MemWords];

	rvx_pkg::rsp_t expected_rsps [$];
	int   mismatches = 0;
	int   cycle_count = 0;
	bit   quiet_phase;
	bit   hold_rsp = 1'b0;

	// Directed table: item, whether a typed result applies, and that result.
	rvx_pkg::req_t dir_req [NumDirected];
	bit            dir_has [NumDirected];
	rvx_pkg::rsp_t dir_rsp [NumDirected];

	function automatic rvx_pkg::req_t make_req(rvx_pkg::op_t op, logic [4:0] rd,
			logic [4:0] rs1, logic [4:0] rs2, logic [19:0] imm);
		rvx_pkg::req_t r;
		r.req_type = op;
		r.dest_index = rd;
		r.src_one_index = rs1;
		r.src_two_index = rs2;
		r.imm_bits = imm;
		return r;
	endfunction

	function automatic rvx_pkg::rsp_t make_rsp(logic [31:0] pc, logic wr, logic [4:0] idx,
			logic [31:0] val, logic mw, logic bad);
		rvx_pkg::rsp_t r;
		r.next_pc = pc;
		r.reg_write = wr;
		r.written_index = idx;
		r.written_value = val;
		r.mem_write = mw;
		r.illegal = bad;
		return r;
	endfunction

	function automatic logic [rvx_pkg::MemAw-1:0] word_addr(logic [31:0] addr);
		return rvx_pkg::MemAw'((addr >> 2) % rvx_pkg::MemWords);
	endfunction

	// Executes one instruction on the model state and returns its response.
	function automatic rvx_pkg::rsp_t execute_instr(rvx_pkg::req_t r);
		logic [31:0]  a, b, imm, val, nxt;
		logic [4:0]   shamt;
		logic         wr_reg, wr_mem, bad;
		rvx_pkg::op_t op;
		a = (r.src_one_index == 5'd0) ? 32'd0 : model_regs[r.src_one_index];
		b = (r.src_two_index == 5'd0) ? 32'd0 : model_regs[r.src_two_index];
		imm = {{20{r.imm_bits[11]}}, r.imm_bits[11:0]};
		shamt = r.imm_bits[4:0];
		nxt = model_pc + 32'd4;
		val = '0;
		wr_reg = 1'b1;
		wr_mem = 1'b0;
		bad = 1'b0;
		op = rvx_pkg::op_t'(r.req_type);
		case (op)
			rvx_pkg::OP_ADDI: val = a + imm;
			rvx_pkg::OP_SLTI: val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
			rvx_pkg::OP_SLTIU: val = (a < imm) ? 32'd1 : 32'd0;
			rvx_pkg::OP_XORI: val = a ^ imm;
			rvx_pkg::OP_ORI: val = a | imm;
			rvx_pkg::OP_ANDI: val = a & imm;
			rvx_pkg::OP_JALR: begin
				val = model_pc + 32'd4;
				nxt = (a + imm) & ~32'd1;
			end
			rvx_pkg::OP_LW: val = model_mem[word_addr(a + imm)];
			rvx_pkg::OP_SLLI: val = a << shamt;
			rvx_pkg::OP_SRLI: val = a >> shamt;
			rvx_pkg::OP_SRAI: val = $unsigned($signed(a) >>> shamt);
			rvx_pkg::OP_AUIPC: val = model_pc + {r.imm_bits, 12'd0};
			rvx_pkg::OP_SW: begin
				wr_reg = 1'b0;
				wr_mem = 1'b1;
				val = b;
				model_mem[word_addr(a + imm)] = b;
			end
			default: begin
				wr_reg = 1'b0;
				bad = 1'b1;
				nxt = model_pc;
			end
		endcase
		if (wr_reg && r.dest_index == 5'd0) begin
			wr_reg = 1'b0;
			val = '0;
		end
		if (wr_reg)
			model_regs[r.dest_index] = val;
		if (!wr_reg && !wr_mem)
			val = '0;
		model_pc = nxt;
		return make_rsp(nxt, wr_reg, wr_reg ? r.dest_index : 5'd0, val, wr_mem, bad);
	endfunction

	// Random instruction: mostly legal ops, registers biased toward a few so
	// that loads see stored data and sources carry interesting values.
	function automatic rvx_pkg::req_t random_instr();
		rvx_pkg::req_t r;
		r.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
			: 4'($urandom_range(0, 12));
		r.dest_index = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 7));
		r.src_one_index = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 7));
		r.src_two_index = 5'($urandom_range(0, 31));
		case ($urandom_range(0, 3))
			0: r.imm_bits = 20'($urandom_range(0, 15) << 2);
			1: r.imm_bits = 20'($urandom_range(0, 20'hfffff));
			default: r.imm_bits = {8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095))};
		endcase
		return r;
	endfunction

	task automatic send_instr(rvx_pkg::req_t r, bit idle_ok);
		int gap;
		if (idle_ok && !quiet_phase && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		rvx_pkg::rsp_t exp;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		quiet_phase = 1'b0;
		model_pc = '0;
		for (int i = 0; i < 32; i++)
			model_regs[i] = '0;
		for (int i = 0; i < rvx_pkg::MemWords; i++)
			model_mem[i] = '0;

		// Directed rows. Typed results follow from reset state and x0 reads.
		dir_req[0] = make_req(rvx_pkg::OP_ADDI, 5'd0, 5'd0, 5'd0, 20'h00005);
		dir_has[0] = 1'b1;
		dir_rsp[0] = make_rsp(32'd4, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0);
		dir_req[1] = make_req(rvx_pkg::OP_LW, 5'd31, 5'd0, 5'd0, 20'h007fc);
		dir_has[1] = 1'b1;
		dir_rsp[1] = make_rsp(32'd8, 1'b1, 5'd31, 32'd0, 1'b0, 1'b0);
		dir_req[2] = make_req(rvx_pkg::OP_BAD13, 5'd31, 5'd31, 5'd31, 20'hfffff);
		dir_has[2] = 1'b1;
		dir_rsp[2] = make_rsp(32'd8, 1'b0, 5'd0, 32'd0, 1'b0, 1'b1);
		dir_req[3] = make_req(rvx_pkg::OP_ADDI, 5'd1, 5'd0, 5'd0, 20'h00800);
		dir_has[3] = 1'b1;
		dir_rsp[3] = make_rsp(32'd12, 1'b1, 5'd1, 32'hfffff800, 1'b0, 1'b0);
		dir_req[4] = make_req(rvx_pkg::OP_ADDI, 5'd2, 5'd0, 5'd0, 20'hff7ff);
		dir_has[4] = 1'b1;
		dir_rsp[4] = make_rsp(32'd16, 1'b1, 5'd2, 32'h000007ff, 1'b0, 1'b0);
		dir_req[5] = make_req(rvx_pkg::OP_SLTI, 5'd3, 5'd1, 5'd0, 20'h00000);
		dir_has[5] = 1'b0;
		dir_req[6] = make_req(rvx_pkg::OP_SLTIU, 5'd4, 5'd1, 5'd0, 20'h00fff);
		dir_has[6] = 1'b0;
		dir_req[7] = make_req(rvx_pkg::OP_XORI, 5'd5, 5'd1, 5'd0, 20'h00fff);
		dir_has[7] = 1'b0;
		dir_req[8] = make_req(rvx_pkg::OP_ORI, 5'd6, 5'd2, 5'd0, 20'h00800);
		dir_has[8] = 1'b0;
		dir_req[9] = make_req(rvx_pkg::OP_ANDI, 5'd7, 5'd1, 5'd0, 20'h00abc);
		dir_has[9] = 1'b0;
		dir_req[10] = make_req(rvx_pkg::OP_SRAI, 5'd8, 5'd1, 5'd0, 20'hfffff);
		dir_has[10] = 1'b0;
		dir_req[11] = make_req(rvx_pkg::OP_SRAI, 5'd9, 5'd1, 5'd0, 20'h00000);
		dir_has[11] = 1'b0;
		dir_req[12] = make_req(rvx_pkg::OP_SRLI, 5'd10, 5'd1, 5'd0, 20'h0003f);
		dir_has[12] = 1'b0;
		dir_req[13] = make_req(rvx_pkg::OP_SLLI, 5'd11, 5'd2, 5'd0, 20'h00021);
		dir_has[13] = 1'b0;
		dir_req[14] = make_req(rvx_pkg::OP_SW, 5'd31, 5'd1, 5'd1, 20'h00003);
		dir_has[14] = 1'b0;
		dir_req[15] = make_req(rvx_pkg::OP_LW, 5'd12, 5'd1, 5'd0, 20'h00000);
		dir_has[15] = 1'b0;
		dir_req[16] = make_req(rvx_pkg::OP_SW, 5'd0, 5'd0, 5'd2, 20'h00ffc);
		dir_has[16] = 1'b0;
		dir_req[17] = make_req(rvx_pkg::OP_AUIPC, 5'd13, 5'd0, 5'd0, 20'hfffff);
		dir_has[17] = 1'b0;
		// jalr reading and writing the same register, with bit 1 kept.
		dir_req[18] = make_req(rvx_pkg::OP_JALR, 5'd2, 5'd2, 5'd0, 20'h00003);
		dir_has[18] = 1'b0;
		dir_req[19] = make_req(rvx_pkg::OP_JALR, 5'd0, 5'd0, 5'd0, 20'h00101);
		dir_has[19] = 1'b0;
		dir_req[20] = make_req(rvx_pkg::OP_BAD14, 5'd1, 5'd1, 5'd1, 20'h0);
		dir_has[20] = 1'b0;
		dir_req[21] = make_req(rvx_pkg::OP_BAD15, 5'd1, 5'd1, 5'd1, 20'h0);
		dir_has[21] = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NumDirected; i++) begin
			exp = execute_instr(dir_req[i]);
			if (dir_has[i] && exp != dir_rsp[i])
				$display("directed row %0d: table disagrees with prediction", i);
			expected_rsps.push_back(dir_has[i] ? dir_rsp[i] : exp);
			send_instr(dir_req[i], 1'b1);
		end
		for (int i = 0; i < NumRandom; i++) begin
			rvx_pkg::req_t r;
			if (i == 300)
				hold_rsp = 1'b1;
			if (i == NumRandom - 200)
				quiet_phase = 1'b1;
			r = random_instr();
			expected_rsps.push_back(execute_instr(r));
			send_instr(r, 1'b1);
		end
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, none at the end.
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !held) begin
				rsp_ready <= 1'b0;
				repeat (60) @(negedge clk);
				held = 1'b1;
			end
			if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				gap = $urandom_range(1, 12);
				repeat (gap - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Response checker.
	always @(posedge clk) begin
		rvx_pkg::rsp_t exp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response transfer: %p", rsp);
			end else begin
				exp = expected_rsps.pop_front();
				if (rsp !== exp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: expected %p, got %p", exp, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MaxCycles) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule
